FILE: sv/bvst_pkg.sv
// ----------------------------------------------------------------------------
// bvst_pkg
// Types, constants and the ln table shared by the shear-thinning viscosity
// pipeline.
// ----------------------------------------------------------------------------
package bvst_pkg;

   localparam int LN_N      = 256;
   localparam int LN_IDX_W  = $clog2(LN_N);
   localparam int LN_ADDR_W = $clog2(LN_N + 1);
   localparam int SC_W      = 32 + LN_IDX_W;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   localparam int NUM_W     = 50;
   localparam int Y_W       = 49;
   localparam int Q_W       = 29;
   localparam int DIV_STEPS = Q_W;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ZS_C0 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZS_C1 = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZS_C2 = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HS_C0 = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HS_C1 = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HS_C2 = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TC_C1 = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TC_C2 = 8'd7;

   typedef struct packed {
      logic [15:0] hematocrit;
      logic [31:0] shear_rate;
   } in_type;

   typedef struct packed {
      logic signed [31:0] viscosity;
      logic               saturated;
   } out_type;

   typedef struct packed {
      logic signed [31:0] zs_c0;
      logic signed [31:0] zs_c1;
      logic signed [31:0] zs_c2;
      logic signed [31:0] hs_c0;
      logic signed [31:0] hs_c1;
      logic signed [31:0] hs_c2;
      logic signed [31:0] tc_c1;
      logic signed [31:0] tc_c2;
   } cfg_type;

   typedef struct packed {
      logic signed [33:0] lt;
      logic signed [34:0] n0;
      logic signed [34:0] ni;
      logic [31:0]        shear;
   } poly_type;

   typedef struct packed {
      logic signed [35:0] diff;
      logic signed [34:0] ni;
   } side_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [Y_W-1:0]   y;
      side_type         side;
   } ln_out_type;

   typedef struct packed {
      logic [Q_W-1:0] q;
      side_type       side;
   } div_out_type;

   typedef logic [31:0] ln_tab_type [0:LN_N];

   // Shift-and-subtract division, used only while the table is built.
   function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [64:0] r;
      q = 64'd0;
      r = 65'd0;
      for (int k = 63; k >= 0; k--) begin
         r = {r[63:0], a[k]};
         if (r >= {1'b0, b}) begin
            r    = r - {1'b0, b};
            q[k] = 1'b1;
         end
      end
      return q;
   endfunction

   // ln(1 + i/N) in Q0.32 from the atanh series, evaluated at elaboration.
   function automatic logic [31:0] ln_entry(input int unsigned i);
      logic [63:0] n;
      logic [63:0] z;
      logic [63:0] zsq;
      logic [63:0] term;
      logic [63:0] sum;
      n    = 64'(LN_N);
      z    = udiv64(64'(i) << 32, 2 * n + 64'(i));
      zsq  = (z * z) >> 32;
      term = z;
      sum  = 64'd0;
      for (int k = 0; k < 64; k++) begin
         if (term != 64'd0) begin
            sum  = sum + udiv64(term, 2 * 64'(k) + 64'd1);
            term = (term * zsq) >> 32;
         end
      end
      return 32'(2 * sum);
   endfunction

   function automatic ln_tab_type build_ln_table();
      ln_tab_type t;
      for (int i = 0; i <= LN_N; i++) begin
         t[i] = ln_entry(i);
      end
      return t;
   endfunction

   localparam ln_tab_type LN_TABLE = build_ln_table();

endpackage

FILE: sv/bvst_poly.sv
// ----------------------------------------------------------------------------
// bvst_poly
// Three stages: hematocrit square, coefficient products, rounded sums for
// n0, ni and the time constant.
// ----------------------------------------------------------------------------
module bvst_poly import bvst_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  in_type   in_data,
   input  cfg_type  cfg,
   output logic     out_valid,
   output poly_type out_data
);

   logic        v1_ff, v2_ff, v3_ff;
   logic [15:0] h1_ff;
   logic [31:0] g1_ff, g2_ff;
   logic [31:0] hh1_ff;

   logic signed [48:0] p_ff [0:5];
   logic signed [48:0] p_in [0:5];

   logic [32:0]        hh_rnd;
   logic [15:0]        h2;
   logic signed [16:0] hs;
   logic signed [16:0] h2s;

   logic signed [49:0] s_zs, s_hs, s_tc;
   poly_type           out_in;
   poly_type           out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_comb begin
      hh_rnd = {1'b0, hh1_ff} + 33'd32768;
      h2     = hh_rnd[31:16];
      hs     = $signed({1'b0, h1_ff});
      h2s    = $signed({1'b0, h2});
      p_in[0] = cfg.zs_c1 * hs;
      p_in[1] = cfg.zs_c2 * h2s;
      p_in[2] = cfg.hs_c1 * hs;
      p_in[3] = cfg.hs_c2 * h2s;
      p_in[4] = cfg.tc_c1 * hs;
      p_in[5] = cfg.tc_c2 * h2s;
   end

   always_comb begin
      s_zs = 50'(p_ff[0]) + 50'(p_ff[1]) + 50'sd32768;
      s_hs = 50'(p_ff[2]) + 50'(p_ff[3]) + 50'sd32768;
      s_tc = 50'(p_ff[4]) + 50'(p_ff[5]) + 50'sd32768;
      out_in.n0    = 35'(cfg.zs_c0) + 35'($signed(s_zs[49:16]));
      out_in.ni    = 35'(cfg.hs_c0) + 35'($signed(s_hs[49:16]));
      out_in.lt    = s_tc[49:16];
      out_in.shear = g2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h1_ff  <= in_data.hematocrit;
         g1_ff  <= in_data.shear_rate;
         hh1_ff <= in_data.hematocrit * in_data.hematocrit;
         g2_ff  <= g1_ff;
         for (int i = 0; i < 6; i++) begin
            p_ff[i] <= p_in[i];
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;

endmodule

FILE: sv/bvst_ln.sv
// ----------------------------------------------------------------------------
// bvst_ln
// Six stages: x = L*g, leading-one search, mantissa scaling, table read,
// interpolation, and the numerator of the blend factor.
// ----------------------------------------------------------------------------
module bvst_ln import bvst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_valid,
   input  poly_type   in_data,
   output logic       out_valid,
   output ln_out_type out_data
);

   logic [5:0] v_ff;

   // Stage 4
   logic [63:0] x_ff;
   side_type    s4_ff;
   // Stage 5
   logic [Y_W-1:0] y5_ff;
   logic [5:0]     e5_ff;
   side_type       s5_ff;
   // Stage 6
   logic [LN_IDX_W-1:0] idx6_ff;
   logic [31:0]         rem6_ff;
   logic [5:0]          e6_ff;
   logic [Y_W-1:0]      y6_ff;
   side_type            s6_ff;
   // Stage 7
   logic [31:0]    lo7_ff, hi7_ff, rem7_ff;
   logic [5:0]     e7_ff;
   logic [Y_W-1:0] y7_ff;
   side_type       s7_ff;
   // Stage 8
   logic [31:0]    lo8_ff, ip8_ff;
   logic [5:0]     e8_ff;
   logic [Y_W-1:0] y8_ff;
   side_type       s8_ff;
   // Stage 9
   ln_out_type out_ff;

   logic [Y_W-1:0]      y_in;
   logic [5:0]          e_in;
   logic [63:0]         norm;
   logic [31:0]         f32;
   logic [SC_W-1:0]     scaled;
   logic [LN_ADDR_W-1:0] addr_lo, addr_hi;
   logic [63:0]         ip_prod;
   logic [38:0]         lny;
   ln_out_type          out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   // The leading one of y sits between bit 16 and bit 48; e is its place
   // above bit 16.
   always_comb begin
      y_in = {1'b0, x_ff[63:16]} + 49'd65536;
      e_in = 6'd0;
      for (int p = 17; p < Y_W; p++) begin
         if (y_in[p]) begin
            e_in = 6'(p - 16);
         end
      end
   end

   always_comb begin
      norm    = {15'd0, y5_ff} << (6'd47 - e5_ff);
      f32     = norm[62:31];
      scaled  = SC_W'(f32) * SC_W'(LN_N);
      addr_lo = LN_ADDR_W'(idx6_ff);
      addr_hi = LN_ADDR_W'(idx6_ff) + LN_ADDR_W'(1);
      ip_prod = (hi7_ff - lo7_ff) * rem7_ff;
      lny     = 39'(e8_ff) * 39'(LN2_Q32) + 39'(lo8_ff) + 39'(ip8_ff);
      out_in.num  = NUM_W'((39'd1 << 32) + lny) << 12;
      out_in.y    = y8_ff;
      out_in.side = s8_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff       <= (in_data.lt > 34'sd0) ? (in_data.lt[31:0] * in_data.shear) : 64'd0;
         s4_ff.diff <= 36'(in_data.n0) - 36'(in_data.ni);
         s4_ff.ni   <= in_data.ni;

         y5_ff <= y_in;
         e5_ff <= e_in;
         s5_ff <= s4_ff;

         idx6_ff <= scaled[SC_W-1:32];
         rem6_ff <= scaled[31:0];
         e6_ff   <= e5_ff;
         y6_ff   <= y5_ff;
         s6_ff   <= s5_ff;

         lo7_ff  <= LN_TABLE[addr_lo];
         hi7_ff  <= LN_TABLE[addr_hi];
         rem7_ff <= rem6_ff;
         e7_ff   <= e6_ff;
         y7_ff   <= y6_ff;
         s7_ff   <= s6_ff;

         lo8_ff <= lo7_ff;
         ip8_ff <= ip_prod[63:32];
         e8_ff  <= e7_ff;
         y8_ff  <= y7_ff;
         s8_ff  <= s7_ff;

         out_ff <= out_in;
      end
   end

   assign out_valid = v_ff[5];
   assign out_data  = out_ff;

endmodule

FILE: sv/bvst_div.sv
// ----------------------------------------------------------------------------
// bvst_div
// Restoring divider, one quotient bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
module bvst_div import bvst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  ln_out_type  in_data,
   output logic        out_valid,
   output div_out_type out_data
);

   typedef struct packed {
      logic [NUM_W-1:0] r;
      logic [Q_W-1:0]   q;
      logic [Y_W-1:0]   y;
      side_type         side;
   } div_stage_type;

   div_stage_type stg_ff [0:DIV_STEPS-1];
   logic          vld_ff [0:DIV_STEPS-1];
   div_stage_type stg_in [0:DIV_STEPS-1];
   div_stage_type src    [0:DIV_STEPS-1];
   logic          vsrc   [0:DIV_STEPS-1];

   genvar j;
   generate
      for (j = 0; j < DIV_STEPS; j++) begin : g_step
         localparam int B = DIV_STEPS - 1 - j;
         if (j == 0) begin : g_first
            always_comb begin
               src[j].r    = in_data.num;
               src[j].q    = '0;
               src[j].y    = in_data.y;
               src[j].side = in_data.side;
               vsrc[j]     = in_valid;
            end
         end else begin : g_next
            always_comb begin
               src[j]  = stg_ff[j-1];
               vsrc[j] = vld_ff[j-1];
            end
         end

         always_comb begin
            stg_in[j] = src[j];
            if ((src[j].r >> B) >= NUM_W'(src[j].y)) begin
               stg_in[j].r    = src[j].r - (NUM_W'(src[j].y) << B);
               stg_in[j].q[B] = 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[j] <= 1'b0;
            end else if (adv) begin
               vld_ff[j] <= vsrc[j];
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               stg_ff[j] <= stg_in[j];
            end
         end
      end
   endgenerate

   assign out_valid     = vld_ff[DIV_STEPS-1];
   assign out_data.q    = stg_ff[DIV_STEPS-1].q;
   assign out_data.side = stg_ff[DIV_STEPS-1].side;

endmodule

FILE: sv/bvst_blend.sv
// ----------------------------------------------------------------------------
// bvst_blend
// Split product (n0-ni)*f, rounding, offset by ni and saturation into the
// result register.
// ----------------------------------------------------------------------------
module bvst_blend import bvst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  div_out_type in_data,
   output logic        out_valid,
   output out_type     out_data
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic [46:0]        plo1_ff;
   logic signed [17:0] dhi1_ff;
   logic [Q_W-1:0]     f1_ff;
   logic signed [34:0] ni1_ff;

   logic [46:0]        plo2_ff;
   logic signed [47:0] phi2_ff;
   logic signed [34:0] ni2_ff;

   logic signed [65:0] prod3_ff;
   logic signed [34:0] ni3_ff;

   out_type out_ff;

   logic signed [65:0] prod_in;
   logic signed [65:0] rnd;
   logic signed [38:0] nu;
   out_type            out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      prod_in = (66'(phi2_ff) <<< 18) + $signed({19'd0, plo2_ff});
      rnd     = prod3_ff + 66'sd134217728;
      nu      = 39'(ni3_ff) + 39'($signed(rnd[65:28]));
      if (nu > 39'sd2147483647) begin
         out_in.viscosity = 32'sh7FFFFFFF;
         out_in.saturated = 1'b1;
      end else if (nu < -39'sd2147483648) begin
         out_in.viscosity = 32'sh80000000;
         out_in.saturated = 1'b1;
      end else begin
         out_in.viscosity = nu[31:0];
         out_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plo1_ff <= 47'(in_data.side.diff[17:0]) * 47'(in_data.q);
         dhi1_ff <= in_data.side.diff[35:18];
         f1_ff   <= in_data.q;
         ni1_ff  <= in_data.side.ni;

         plo2_ff <= plo1_ff;
         phi2_ff <= 48'(dhi1_ff) * $signed({19'd0, f1_ff});
         ni2_ff  <= ni1_ff;

         prod3_ff <= prod_in;
         ni3_ff   <= ni2_ff;

         out_ff <= out_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = out_ff;

endmodule

FILE: sv/blood_viscosity_shear_thinning_core.sv
// Throughput: one beat per cycle unless the response is stalled; the 29-stage
// restoring divider and the split multiplies are fully pipelined, so every
// stage advances together. A stalled valid response holds the whole pipeline
// and raises req_stall. Reset (synchronous, active high) clears all valid bits
// and the eight coefficient registers to zero.
// ----------------------------------------------------------------------------
// blood_viscosity_shear_thinning_core
// Hematocrit dependent shear-thinning blood viscosity, one cell per beat.
// ----------------------------------------------------------------------------
module blood_viscosity_shear_thinning_core import bvst_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  in_type               req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output out_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   cfg_type cfg_ff;
   logic    adv;

   logic        poly_valid, ln_valid, div_valid;
   poly_type    poly_data;
   ln_out_type  ln_data;
   div_out_type div_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ZS_C0: cfg_ff.zs_c0 <= csr_wdata;
            CSR_ZS_C1: cfg_ff.zs_c1 <= csr_wdata;
            CSR_ZS_C2: cfg_ff.zs_c2 <= csr_wdata;
            CSR_HS_C0: cfg_ff.hs_c0 <= csr_wdata;
            CSR_HS_C1: cfg_ff.hs_c1 <= csr_wdata;
            CSR_HS_C2: cfg_ff.hs_c2 <= csr_wdata;
            CSR_TC_C1: cfg_ff.tc_c1 <= csr_wdata;
            CSR_TC_C2: cfg_ff.tc_c2 <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The pipeline moves whenever the result register is empty or drained.
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   bvst_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (poly_valid),
      .out_data  (poly_data)
   );

   bvst_ln u_ln (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (poly_valid),
      .in_data   (poly_data),
      .out_valid (ln_valid),
      .out_data  (ln_data)
   );

   bvst_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ln_valid),
      .in_data   (ln_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   bvst_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

FILE: sv/bvst_checker.sv
// ----------------------------------------------------------------------------
// bvst_checker
// Port-level checks for the viscosity core, bound to the top level.
// ----------------------------------------------------------------------------
module bvst_checker import bvst_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input out_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         (rsp_data.viscosity == 32'sh7FFFFFFF || rsp_data.viscosity == 32'sh80000000))
      else $error("saturated beat not at a limit");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while the result register is empty");

endmodule

bind blood_viscosity_shear_thinning_core bvst_checker u_bvst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: dv/blood_viscosity_shear_thinning_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blood_viscosity_shear_thinning_core_tb
// Drives cells through the viscosity pipeline under several coefficient
// sets, predicts every response beat in fixed point and compares it field by
// field, with random gaps on the request side and random response stalls.
// ----------------------------------------------------------------------------
module blood_viscosity_shear_thinning_core_tb;
   import bvst_pkg::*;

   localparam int  LOG_N      = 256;
   localparam longint unsigned LOG2_Q32 = 64'd2977044472;
   localparam int  IDLE_LIMIT = 5000;
   localparam int  DRAIN_WAIT = 60;
   localparam int  PHASES     = 7;

   localparam logic [CSR_IDX_W-1:0] COEF_IDX [8] = '{CSR_ZS_C0, CSR_ZS_C1, CSR_ZS_C2,
      CSR_HS_C0, CSR_HS_C1, CSR_HS_C2, CSR_TC_C1, CSR_TC_C2};

   // -------------------------------------------------------------------------
   class viscosity_scoreboard;
      longint          coef [8];
      longint unsigned log_tab [LOG_N+1];
      out_type         pending_q [$];
      int              fails;

      function new();
         longint unsigned z, zsq, term, sum;
         for (int i = 0; i <= LOG_N; i++) begin
            z    = (longint'(i) << 32) / (2 * LOG_N + i);
            zsq  = (z * z) >> 32;
            term = z;
            sum  = 0;
            for (int k = 0; k < 64 && term != 0; k++) begin
               sum  = sum + term / (2 * k + 1);
               term = (term * zsq) >> 32;
            end
            log_tab[i] = 2 * sum;
         end
         foreach (coef[i]) coef[i] = 0;
         fails = 0;
      endfunction

      function void set_coef(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         if (idx < 8) coef[idx] = longint'(signed'(data));
      endfunction

      function longint rnd16(longint v);
         return (v + 64'sd32768) >>> 16;
      endfunction

      // Natural log of a Q16.16 value of at least one, result in Q32.
      function longint unsigned log_q32(longint unsigned y);
         int p;
         longint unsigned frac, scaled, idx, rem, lo, hi;
         p = 63;
         while (p > 16 && y[p] == 1'b0) p--;
         if (p >= 32) frac = (y >> (p - 32)) & 64'hFFFF_FFFF;
         else         frac = (y << (32 - p)) & 64'hFFFF_FFFF;
         scaled = frac * LOG_N;
         idx    = scaled >> 32;
         rem    = scaled & 64'hFFFF_FFFF;
         if (idx > LOG_N - 1) idx = LOG_N - 1;
         lo = log_tab[idx];
         hi = log_tab[idx + 1];
         return longint'(p - 16) * LOG2_Q32 + lo + (((hi - lo) * rem) >> 32);
      endfunction

      function out_type viscosity_of(in_type item);
         longint h, h2, n0, ni, lt, diff, nu;
         longint unsigned g, x, y, lny, f;
         out_type r;
         h  = longint'(item.hematocrit);
         g  = longint'(item.shear_rate);
         h2 = (h * h + 32768) >>> 16;
         n0 = coef[0] + rnd16(coef[1] * h + coef[2] * h2);
         ni = coef[3] + rnd16(coef[4] * h + coef[5] * h2);
         lt = rnd16(coef[6] * h + coef[7] * h2);
         // A non-positive time constant means no thinning at all.
         x  = (lt > 0) ? ((longint'(unsigned'(lt)) * g) >> 16) : 64'd0;
         y  = x + 64'd65536;
         lny = log_q32(y);
         f  = ((64'h1_0000_0000 + lny) << 12) / y;
         diff = n0 - ni;
         nu = ni + ((diff * longint'(f) + 64'sd134217728) >>> 28);
         r.saturated = 1'b0;
         if (nu > 64'sd2147483647) begin
            nu = 64'sd2147483647;
            r.saturated = 1'b1;
         end else if (nu < -64'sd2147483648) begin
            nu = -64'sd2147483648;
            r.saturated = 1'b1;
         end
         r.viscosity = nu[31:0];
         return r;
      endfunction

      function void note_cell(in_type item);
         pending_q.push_back(viscosity_of(item));
      endfunction

      function void check_beat(out_type got);
         out_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: response beat with nothing pending: viscosity %0d saturated %0b",
                     $time, got.viscosity, got.saturated);
            fails++;
            return;
         end
         want = pending_q.pop_front();
         if (got.viscosity !== want.viscosity) begin
            $display("%0t: viscosity expected %0d actual %0d", $time,
                     want.viscosity, got.viscosity);
            fails++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time,
                     want.saturated, got.saturated);
            fails++;
         end
      endfunction
   endclass
   // -------------------------------------------------------------------------

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   in_type               req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   out_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   viscosity_scoreboard sb = new();
   bit  quiet = 1'b0;
   int  idle_cycles = 0;
   int  stall_left = 0;

   blood_viscosity_shear_thinning_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Response stalls: mostly short bursts, now and then a long one.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         int g;
         g = pick_gap();
         stall_left <= (g > 0) ? g - 1 : 0;
         rsp_stall  <= (g > 0);
      end
   end

   // Beat monitor and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_cell(req_data);
         if (rsp_valid && !rsp_stall) sb.check_beat(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Leaves csr_valid high; the caller lowers it after the last write.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_coef(idx, data);
   endtask

   task automatic send_cell(in_type item);
      int gap;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic in_type random_cell();
      in_type c;
      case ($urandom_range(0, 7))
         0:       c.hematocrit = 16'h0000;
         1:       c.hematocrit = 16'hFFFF;
         2, 3:    c.hematocrit = 16'($urandom_range(13000, 39000));
         default: c.hematocrit = 16'($urandom());
      endcase
      case ($urandom_range(0, 9))
         0:       c.shear_rate = 32'h0;
         1:       c.shear_rate = 32'hFFFF_FFFF;
         2, 3, 4: c.shear_rate = $urandom_range(0, 32'h0010_0000);
         5, 6:    c.shear_rate = $urandom_range(0, 32'h0400_0000);
         default: c.shear_rate = $urandom();
      endcase
      return c;
   endfunction

   function automatic logic [31:0] coef_for(int phase, int i);
      case (phase)
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         4: return (i >= 6) ? -$urandom_range(0, 32'h0100_0000) : $urandom();
         5: return $urandom();
         default: begin
            case (i)
               0:       return $urandom_range(2000000, 5000000);
               3:       return $urandom_range(500000, 2000000);
               6, 7:    return $urandom_range(0, 32'h0010_0000);
               default: return $urandom_range(0, 32'h0100_0000);
            endcase
         end
      endcase
   endfunction

   initial begin
      in_type item;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < PHASES; phase++) begin
         quiet = (phase == 5);
         if (phase > 0) begin
            // Indexes past the register list must be ignored.
            write_reg($urandom_range(8, 255), $urandom());
            for (int i = 0; i < 8; i++) write_reg(COEF_IDX[i], coef_for(phase, i));
            csr_valid <= 1'b0;
            @(posedge clock);
         end
         if (phase == 1) begin
            for (int hi = 0; hi < 3; hi++) begin
               for (int gi = 0; gi < 4; gi++) begin
                  item.hematocrit = (hi == 0) ? 16'h0 : (hi == 1) ? 16'hFFFF : 16'h8000;
                  item.shear_rate = (gi == 0) ? 32'h0 : (gi == 1) ? 32'h1 :
                                    (gi == 2) ? 32'hFFFF_FFFF : 32'h0001_0000;
                  send_cell(item);
               end
            end
         end
         for (int n = 0; n < ((phase == 0) ? 30 : 270); n++) send_cell(random_cell());
         req_valid <= 1'b0;
         wait (sb.pending_q.size() == 0);
         repeat (DRAIN_WAIT) @(posedge clock);
      end
      if (sb.fails == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: blood_viscosity_shear_thinning_core.f
sv/bvst_pkg.sv
sv/bvst_poly.sv
sv/bvst_ln.sv
sv/bvst_div.sv
sv/bvst_blend.sv
sv/blood_viscosity_shear_thinning_core.sv
sv/bvst_checker.sv
dv/blood_viscosity_shear_thinning_core_tb.sv
